### design/second_difference_top_n_tracker_macros.svh
// Assertion macros for the second difference top-N tracker.
`ifndef SECOND_DIFFERENCE_TOP_N_TRACKER_MACROS_SVH
`define SECOND_DIFFERENCE_TOP_N_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define SDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdt assertion failed");
// Next-cycle implication, disabled while in reset.
`define SDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdt assertion failed");
`else
`define SDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/sdt_pkg.sv
// Shared types and constants of the second difference top-N tracker.
package sdt_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int TOP_W           = 7;
  localparam int RANK_W          = 6;
  localparam int IDX_W           = 32;
  localparam int SUM_W           = 50;

  localparam logic [TOP_W-1:0] TOP_RESET = 7'd22;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic ins;      // a new difference is offered this cycle
    logic active;   // cell sits inside the kept part of the list
    logic gt_left;  // new magnitude beats the left neighbor
  } cell_ctl_t;

endpackage

### design/sdt_cell.sv
// One ranked list slot: holds a difference, its magnitude and its index.
module sdt_cell #(
  parameter int SAMPLE_BITS = sdt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdt_pkg::cell_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS+1:0] new_diff,
  input  logic        [SAMPLE_BITS:0]   new_mag,
  input  logic [sdt_pkg::IDX_W-1:0]     new_idx,
  input  logic signed [SAMPLE_BITS+1:0] left_diff,
  input  logic        [SAMPLE_BITS:0]   left_mag,
  input  logic [sdt_pkg::IDX_W-1:0]     left_idx,
  output logic signed [SAMPLE_BITS+1:0] diff,
  output logic        [SAMPLE_BITS:0]   mag,
  output logic [sdt_pkg::IDX_W-1:0]     idx,
  output logic                          gt
);
  import sdt_pkg::*;

  logic signed [SAMPLE_BITS+1:0] diff_r, diff_nxt;
  logic        [SAMPLE_BITS:0]   mag_r, mag_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;

  assign gt = new_mag > mag_r;

  // List is kept in descending magnitude, so gt is monotone along the row:
  // the left neighbor winning means this slot shifts right by one.
  always_comb begin
    diff_nxt = diff_r;
    mag_nxt  = mag_r;
    idx_nxt  = idx_r;
    if (ctl.ins && ctl.active) begin
      priority if (ctl.gt_left) begin
        diff_nxt = left_diff;
        mag_nxt  = left_mag;
        idx_nxt  = left_idx;
      end else if (gt) begin
        diff_nxt = new_diff;
        mag_nxt  = new_mag;
        idx_nxt  = new_idx;
      end else begin
        diff_nxt = diff_r;
        mag_nxt  = mag_r;
        idx_nxt  = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
      mag_r  <= '0;
      idx_r  <= '0;
    end else begin
      diff_r <= diff_nxt;
      mag_r  <= mag_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign diff = diff_r;
  assign mag  = mag_r;
  assign idx  = idx_r;

endmodule

### design/sdt_chain.sv
// Row of list cells with sorted insertion and the ranked read port.
module sdt_chain #(
  parameter int MAX_ENTRIES = sdt_pkg::MAX_ENTRIES_DEF,
  parameter int SAMPLE_BITS = sdt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ins,
  input  logic [sdt_pkg::TOP_W-1:0]      top_count,
  input  logic signed [SAMPLE_BITS+1:0]  new_diff,
  input  logic        [SAMPLE_BITS:0]    new_mag,
  input  logic [sdt_pkg::IDX_W-1:0]      new_idx,
  input  logic [sdt_pkg::RANK_W-1:0]     rd_rank,
  output logic signed [SAMPLE_BITS+1:0]  rd_diff,
  output logic [sdt_pkg::IDX_W-1:0]      rd_idx,
  output logic                           rd_hit
);
  import sdt_pkg::*;

  logic signed [SAMPLE_BITS+1:0] c_diff [MAX_ENTRIES];
  logic        [SAMPLE_BITS:0]   c_mag  [MAX_ENTRIES];
  logic [IDX_W-1:0]              c_idx  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        c_gt;
  logic [MAX_ENTRIES-1:0]        active;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    cell_ctl_t                     ctl;
    logic signed [SAMPLE_BITS+1:0] l_diff;
    logic        [SAMPLE_BITS:0]   l_mag;
    logic [IDX_W-1:0]              l_idx;

    // top_count of zero still keeps slot 0
    assign active[g] = (g == 0) || (g < int'(top_count));

    if (g == 0) begin : g_head
      assign l_diff      = '0;
      assign l_mag       = '0;
      assign l_idx       = '0;
      assign ctl.gt_left = 1'b0;
    end else begin : g_body
      assign l_diff      = c_diff[g-1];
      assign l_mag       = c_mag[g-1];
      assign l_idx       = c_idx[g-1];
      assign ctl.gt_left = c_gt[g-1];
    end
    assign ctl.ins    = ins;
    assign ctl.active = active[g];

    sdt_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_diff (new_diff),
      .new_mag  (new_mag),
      .new_idx  (new_idx),
      .left_diff(l_diff),
      .left_mag (l_mag),
      .left_idx (l_idx),
      .diff     (c_diff[g]),
      .mag      (c_mag[g]),
      .idx      (c_idx[g]),
      .gt       (c_gt[g])
    );
  end

  // Ranks at or past the kept length read as zero.
  always_comb begin
    rd_diff = '0;
    rd_idx  = '0;
    rd_hit  = 1'b0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (int'(rd_rank) == k && active[k]) begin
        rd_diff = c_diff[k];
        rd_idx  = c_idx[k];
        rd_hit  = 1'b1;
      end
    end
  end

endmodule

### design/second_difference_top_n_tracker.sv
// Second difference tracker: ranked list of the largest differences plus totals.
// Latency: one result per item, registered, valid the cycle after the item beat.
// Throughput: one item per cycle unless stalled; a sorted insertion finishes in that
// cycle in all list cells in parallel; the output register refills while it drains.
// Reset (synchronous, rst_n low): list cells, counters and sum cleared, top_count 22.
`include "second_difference_top_n_tracker_macros.svh"
module second_difference_top_n_tracker #(
  parameter int MAX_ENTRIES = sdt_pkg::MAX_ENTRIES_DEF,
  parameter int SAMPLE_BITS = sdt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic [sdt_pkg::RANK_W-1:0]     in_rank,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS+1:0]  out_diff,
  output logic                           out_diff_valid,
  output logic signed [SAMPLE_BITS+1:0]  out_entry_diff,
  output logic [sdt_pkg::IDX_W-1:0]      out_entry_index,
  output logic                           out_entry_valid,
  output logic [sdt_pkg::SUM_W-1:0]      out_abs_sum,
  output logic [sdt_pkg::IDX_W-1:0]      out_sample_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdt_pkg::TOP_W-1:0]      cfg_data
);
  import sdt_pkg::*;

  localparam int MagW = SAMPLE_BITS + 1;

  phase_t                        phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_sample_r;
  logic signed [SAMPLE_BITS:0]   prev_slope_r;
  logic [IDX_W-1:0]              cnt_r, cnt_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [TOP_W-1:0]              top_count_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS+1:0] out_diff_r, out_entry_diff_r;
  logic                          out_diff_valid_r, out_entry_valid_r;
  logic [IDX_W-1:0]              out_entry_index_r, out_sample_count_r;
  logic [SUM_W-1:0]              out_abs_sum_r;

  logic                          acc, smp_beat, rd_beat, diff_fire, slope_load;
  logic signed [SAMPLE_BITS:0]   slope;
  logic signed [SAMPLE_BITS+1:0] d;
  logic [MagW-1:0]               d_mag;
  logic [SUM_W:0]                sum_wide;
  logic signed [SAMPLE_BITS+1:0] rd_diff;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_hit;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign smp_beat  = acc && !in_kind;
  assign rd_beat   = acc && in_kind;
  assign cfg_ready = 1'b1;

  assign slope = $signed({in_sample[SAMPLE_BITS-1], in_sample})
               - $signed({prev_sample_r[SAMPLE_BITS-1], prev_sample_r});
  assign d     = $signed({slope[SAMPLE_BITS], slope})
               - $signed({prev_slope_r[SAMPLE_BITS], prev_slope_r});
  assign d_mag = d[SAMPLE_BITS+1] ? MagW'(-d) : MagW'(d);

  // Startup sequencer: first sample only stored, second gives the first slope.
  always_comb begin
    phase_nxt  = phase_r;
    diff_fire  = 1'b0;
    slope_load = 1'b0;
    unique case (phase_r)
      PH_EMPTY: begin
        if (smp_beat) phase_nxt = PH_ONE;
      end
      PH_ONE: begin
        if (smp_beat) begin
          phase_nxt  = PH_RUN;
          slope_load = 1'b1;
        end
      end
      PH_RUN: begin
        diff_fire  = smp_beat;
        slope_load = smp_beat;
      end
      default: phase_nxt = PH_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= PH_EMPTY;
    else        phase_r <= phase_nxt;
  end

  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(d_mag);

  always_comb begin
    sum_nxt = sum_r;
    if (diff_fire) sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    cnt_nxt = cnt_r;
    if (smp_beat && cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_slope_r  <= '0;
      cnt_r         <= '0;
      sum_r         <= '0;
      top_count_r   <= TOP_RESET;
    end else begin
      if (smp_beat)   prev_sample_r <= in_sample;
      if (slope_load) prev_slope_r  <= slope;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      if (cfg_valid && cfg_ready) top_count_r <= cfg_data;
    end
  end

  sdt_chain #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ins      (diff_fire),
    .top_count(top_count_r),
    .new_diff (d),
    .new_mag  (d_mag),
    .new_idx  (cnt_r),
    .rd_rank  (in_rank),
    .rd_diff  (rd_diff),
    .rd_idx   (rd_idx),
    .rd_hit   (rd_hit)
  );

  // Output register: refilled on every item beat, held while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_diff_r         <= diff_fire ? d : '0;
      out_diff_valid_r   <= diff_fire;
      out_entry_diff_r   <= rd_beat ? rd_diff : '0;
      out_entry_index_r  <= rd_beat ? rd_idx : '0;
      out_entry_valid_r  <= rd_beat && rd_hit && (rd_idx != '0);
      out_abs_sum_r      <= sum_nxt;
      out_sample_count_r <= cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_diff         = out_diff_r;
  assign out_diff_valid   = out_diff_valid_r;
  assign out_entry_diff   = out_entry_diff_r;
  assign out_entry_index  = out_entry_index_r;
  assign out_entry_valid  = out_entry_valid_r;
  assign out_abs_sum      = out_abs_sum_r;
  assign out_sample_count = out_sample_count_r;

  `SDT_ASSERT_IMP(a_no_mixed_result, clk, rst_n, out_valid_r && out_diff_valid_r, !out_entry_valid_r)
  `SDT_ASSERT_NXT(a_run_gives_diff, clk, rst_n, smp_beat && phase_r == PH_RUN, out_diff_valid_r)
  `SDT_ASSERT_NXT(a_read_keeps_count, clk, rst_n, rd_beat, out_sample_count_r == $past(cnt_r))
  `SDT_ASSERT_IMP(a_empty_zero_count, clk, rst_n, phase_r == PH_EMPTY, cnt_r == '0)

endmodule
